[hw/rtl/lsb_stego_stream_extractor_defines.svh]
// Assertion macros shared by the stego extractor RTL.
`ifndef LSB_STEGO_STREAM_EXTRACTOR_DEFINES_SVH
`define LSB_STEGO_STREAM_EXTRACTOR_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LSB_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and disabled while rst_ni is low.
`define LSB_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/lsb_steg_pkg.sv]
// Shared types, codes and constants of the stego extractor.
`timescale 1ns / 1ps
package lsb_steg_pkg;

  localparam int unsigned ImageByteW   = 8;
  localparam int unsigned PayloadByteW = 8;
  localparam int unsigned SkipW        = 16;
  localparam int unsigned MagicW       = 16;
  localparam int unsigned WordW        = 32;
  localparam int unsigned BitCntW      = 6;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned CfgDataW     = 32;

  // Bits collected for each field of the hidden header.
  localparam logic [BitCntW-1:0] MagicBits = BitCntW'(16);
  localparam logic [BitCntW-1:0] WordBits  = BitCntW'(32);
  localparam logic [BitCntW-1:0] ByteBits  = BitCntW'(8);

  // Register indexes on the configuration port.
  localparam logic [CfgIdxW-1:0] RegHeaderSkip    = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] RegMagicWord     = CfgIdxW'(1);
  localparam logic [CfgIdxW-1:0] RegExtensionWord = CfgIdxW'(2);

  // Register reset values: a 54-byte bitmap header, magic "#&", extension ".txt".
  localparam logic [SkipW-1:0]  HeaderSkipRst    = 16'd54;
  localparam logic [MagicW-1:0] MagicWordRst     = 16'h2326;
  localparam logic [WordW-1:0]  ExtensionWordRst = 32'h2E74_7874;

  typedef enum logic [1:0] {
    KIND_PAYLOAD   = 2'd0,
    KIND_DONE      = 2'd1,
    KIND_MAGIC_ERR = 2'd2,
    KIND_EXT_ERR   = 2'd3
  } kind_e;

  typedef struct packed {
    logic [SkipW-1:0]  header_skip;
    logic [MagicW-1:0] magic_word;
    logic [WordW-1:0]  extension_word;
  } cfg_t;

  typedef struct packed {
    kind_e                   kind;
    logic [PayloadByteW-1:0] payload_byte;
    logic                    last;
  } result_t;

endpackage

[hw/rtl/lsb_steg_cfg_regs.sv]
// Configuration register file of the stego extractor.
`timescale 1ns / 1ps
module lsb_steg_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 we_i,
  input  logic [lsb_steg_pkg::CfgIdxW-1:0]     idx_i,
  input  logic [lsb_steg_pkg::CfgDataW-1:0]    wdata_i,
  output lsb_steg_pkg::cfg_t                   cfg_o
);

  lsb_steg_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (idx_i)
        lsb_steg_pkg::RegHeaderSkip:
          cfg_d.header_skip = wdata_i[lsb_steg_pkg::SkipW-1:0];
        lsb_steg_pkg::RegMagicWord:
          cfg_d.magic_word = wdata_i[lsb_steg_pkg::MagicW-1:0];
        lsb_steg_pkg::RegExtensionWord:
          cfg_d.extension_word = wdata_i[lsb_steg_pkg::WordW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.header_skip    <= lsb_steg_pkg::HeaderSkipRst;
      cfg_q.magic_word     <= lsb_steg_pkg::MagicWordRst;
      cfg_q.extension_word <= lsb_steg_pkg::ExtensionWordRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[hw/rtl/lsb_steg_parser.sv]
// Header skip and hidden-bit parser: one image byte in, at most one result out.
`timescale 1ns / 1ps
module lsb_steg_parser (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  input  logic                    image_bit_i,
  input  logic                    first_byte_i,
  input  lsb_steg_pkg::cfg_t      cfg_i,
  output logic                    res_valid_o,
  output lsb_steg_pkg::result_t   res_o
);

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_SKIP   = 3'd1,
    PH_MAGIC  = 3'd2,
    PH_EXTLEN = 3'd3,
    PH_EXT    = 3'd4,
    PH_SIZE   = 3'd5,
    PH_DATA   = 3'd6
  } phase_e;

  phase_e                                 phase_q, phase_d, ph;
  logic [lsb_steg_pkg::SkipW-1:0]         skip_q, skip_d, skip_cur, skip_inc;
  logic [lsb_steg_pkg::BitCntW-1:0]       cnt_q, cnt_d, cnt_cur, cnt_inc, need;
  logic [lsb_steg_pkg::WordW-1:0]         shift_q, shift_d, shift_cur, shifted;
  logic [lsb_steg_pkg::WordW-1:0]         rem_q, rem_d, rem_cur, rem_dec;

  always_comb begin
    ph        = phase_q;
    skip_cur  = skip_q;
    cnt_cur   = cnt_q;
    shift_cur = shift_q;
    rem_cur   = rem_q;

    // A first-byte marker restarts the file, whatever the parser was doing.
    if (first_byte_i) begin
      skip_cur  = '0;
      rem_cur   = '0;
      cnt_cur   = '0;
      shift_cur = '0;
      ph        = (cfg_i.header_skip == '0) ? PH_MAGIC : PH_SKIP;
    end

    skip_inc = skip_cur + lsb_steg_pkg::SkipW'(1);
    shifted  = {shift_cur[lsb_steg_pkg::WordW-2:0], image_bit_i};
    cnt_inc  = cnt_cur + lsb_steg_pkg::BitCntW'(1);
    rem_dec  = rem_cur - lsb_steg_pkg::WordW'(1);

    if (ph == PH_MAGIC) begin
      need = lsb_steg_pkg::MagicBits;
    end else if (ph == PH_DATA) begin
      need = lsb_steg_pkg::ByteBits;
    end else begin
      need = lsb_steg_pkg::WordBits;
    end

    phase_d = ph;
    skip_d  = skip_cur;
    cnt_d   = cnt_cur;
    shift_d = shift_cur;
    rem_d   = rem_cur;

    res_valid_o        = 1'b0;
    res_o.kind         = lsb_steg_pkg::KIND_PAYLOAD;
    res_o.payload_byte = '0;
    res_o.last         = 1'b0;

    case (ph)
      PH_SKIP: begin
        skip_d = skip_inc;
        // The >= compare keeps a lowered limit from hanging the skip; a wrap also ends it.
        if (skip_inc >= cfg_i.header_skip || skip_inc == '0) begin
          phase_d = PH_MAGIC;
          cnt_d   = '0;
          shift_d = '0;
        end
      end
      PH_MAGIC, PH_EXTLEN, PH_EXT, PH_SIZE, PH_DATA: begin
        shift_d = shifted;
        cnt_d   = cnt_inc;
        if (cnt_inc >= need) begin
          cnt_d   = '0;
          shift_d = '0;
          case (ph)
            PH_MAGIC: begin
              if (shifted[lsb_steg_pkg::MagicW-1:0] != cfg_i.magic_word) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = lsb_steg_pkg::KIND_MAGIC_ERR;
                res_o.last  = 1'b1;
              end else begin
                phase_d = PH_EXTLEN;
              end
            end
            PH_EXTLEN: phase_d = PH_EXT;
            PH_EXT: begin
              if (shifted != cfg_i.extension_word) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = lsb_steg_pkg::KIND_EXT_ERR;
                res_o.last  = 1'b1;
              end else begin
                phase_d = PH_SIZE;
              end
            end
            PH_SIZE: begin
              rem_d = shifted;
              if (shifted == '0) begin
                phase_d     = PH_IDLE;
                res_valid_o = 1'b1;
                res_o.kind  = lsb_steg_pkg::KIND_DONE;
                res_o.last  = 1'b1;
              end else begin
                phase_d = PH_DATA;
              end
            end
            default: begin
              rem_d              = rem_dec;
              res_valid_o        = 1'b1;
              res_o.payload_byte = shifted[lsb_steg_pkg::PayloadByteW-1:0];
              res_o.last         = (rem_dec == '0);
              phase_d            = (rem_dec == '0) ? PH_IDLE : PH_DATA;
            end
          endcase
        end
      end
      default: phase_d = PH_IDLE;
    endcase

    // Nothing happens without an accepted byte.
    if (!in_valid_i) begin
      res_valid_o = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      skip_q  <= '0;
      cnt_q   <= '0;
      shift_q <= '0;
      rem_q   <= '0;
    end else if (in_valid_i) begin
      phase_q <= phase_d;
      skip_q  <= skip_d;
      cnt_q   <= cnt_d;
      shift_q <= shift_d;
      rem_q   <= rem_d;
    end
  end

endmodule

[hw/rtl/lsb_steg_out_buf.sv]
// Two-entry result register with skid stage; ready comes from a flop.
`timescale 1ns / 1ps
module lsb_steg_out_buf (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    push_i,
  input  lsb_steg_pkg::result_t   push_data_i,
  output logic                    ready_o,
  output logic                    out_valid_o,
  output lsb_steg_pkg::result_t   out_data_o,
  input  logic                    out_ready_i
);

  logic                  out_valid_q, out_valid_d;
  logic                  skid_valid_q, skid_valid_d;
  lsb_steg_pkg::result_t out_q, out_d, skid_q, skid_d;

  always_comb begin
    out_valid_d  = out_valid_q;
    out_d        = out_q;
    skid_valid_d = skid_valid_q;
    skid_d       = skid_q;
    if (!out_valid_q || out_ready_i) begin
      if (skid_valid_q) begin
        out_valid_d  = 1'b1;
        out_d        = skid_q;
        skid_valid_d = 1'b0;
      end else begin
        out_valid_d = push_i;
        out_d       = push_data_i;
      end
    end else if (push_i) begin
      skid_valid_d = 1'b1;
      skid_d       = push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      skid_valid_q <= skid_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign ready_o     = !skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

[hw/rtl/lsb_stego_stream_extractor.sv]
// Top level of the LSB steganography stream extractor.
`timescale 1ns / 1ps
`include "lsb_stego_stream_extractor_defines.svh"

// The extractor takes a carrier image file one byte per word on the slave
// stream, with tuser set on the first byte of each file. It skips header_skip
// bytes and then gathers the least significant bit of each byte, most
// significant bit first, into a 16-bit magic marker, a 32-bit extension length
// (read and discarded), a 32-bit extension and a 32-bit payload size; every
// following group of eight bits is sent out on the master stream as one
// payload word, with tlast on the final one. A wrong magic or extension gives a
// single error word with tlast, and an empty payload a single done word; after
// any final word the block ignores input until the next first-byte marker. An
// input word is taken every clock cycle: the parser state updates in one pass
// between the stream input and the result register, and a two-entry result
// buffer (output register plus skid register) keeps tready high while a
// finished word waits on the master side, so a stall there holds the slave
// side only after two words are waiting. Results leave from the output register.
// The user writes configuration registers through the cfg port only while no
// file is in progress; the block itself does not enforce this.
module lsb_stego_stream_extractor (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // Configuration write port.
  input  logic                                   cfg_we_i,
  input  logic [lsb_steg_pkg::CfgIdxW-1:0]       cfg_idx_i,
  input  logic [lsb_steg_pkg::CfgDataW-1:0]      cfg_wdata_i,
  // Slave stream: image bytes.
  input  logic                                   s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  logic [lsb_steg_pkg::ImageByteW-1:0]    s_axis_tdata,  // [7:0] image_byte
  input  logic                                   s_axis_tuser,  // [0] first_byte
  // Master stream: results.
  output logic                                   m_axis_tvalid,
  input  logic                                   m_axis_tready,
  output logic [lsb_steg_pkg::PayloadByteW-1:0]  m_axis_tdata,  // [7:0] payload_byte
  output logic [1:0]                             m_axis_tuser,  // [1:0] kind
  output logic                                   m_axis_tlast
);

  lsb_steg_pkg::cfg_t    cfg;
  lsb_steg_pkg::result_t par_res;
  lsb_steg_pkg::result_t out_res;
  logic                  in_accept;
  logic                  par_res_valid;

  assign in_accept = s_axis_tvalid && s_axis_tready;

  lsb_steg_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .wdata_i (cfg_wdata_i),
    .cfg_o   (cfg)
  );

  // Only bit 0 of each byte carries hidden data.
  lsb_steg_parser u_parser (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_accept),
    .image_bit_i  (s_axis_tdata[0]),
    .first_byte_i (s_axis_tuser),
    .cfg_i        (cfg),
    .res_valid_o  (par_res_valid),
    .res_o        (par_res)
  );

  lsb_steg_out_buf u_out_buf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (par_res_valid),
    .push_data_i (par_res),
    .ready_o     (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_data_o  (out_res),
    .out_ready_i (m_axis_tready)
  );

  assign m_axis_tdata = out_res.payload_byte;
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.last;

  // A result is only produced by an accepted image byte.
  `LSB_ASSERT_IMP(a_res_needs_accept, par_res_valid, in_accept,
                  "parser produced a result without an accepted byte")
  // Every non-payload word closes its file.
  `LSB_ASSERT_IMP(a_status_is_last,
                  m_axis_tvalid && (m_axis_tuser != lsb_steg_pkg::KIND_PAYLOAD),
                  m_axis_tlast && (m_axis_tdata == '0),
                  "status word without tlast or with nonzero data")
  // Back-pressure on the input means both result entries are occupied.
  `LSB_ASSERT_IMP(a_stall_has_output, !s_axis_tready, m_axis_tvalid,
                  "input stalled with no result waiting")
  // A full buffer still holds a word in the next cycle.
  `LSB_ASSERT_NXT(a_full_stays_valid, !s_axis_tready, m_axis_tvalid,
                  "buffered result lost after a full buffer")

endmodule

[verif/lsb_stego_stream_extractor_tb.sv]
// Self-checking testbench for the LSB stego stream extractor: directed files, then random files.
`timescale 1ns / 1ps

// The bench feeds whole carrier files into the slave stream. Each file has a
// header to skip, a hidden magic, extension length, extension, size and payload.
// A behavioral copy of the parser, updated on every accepted byte, predicts the
// result words. The master side compares every word it accepts with the oldest
// prediction, field by field.
module lsb_stego_stream_extractor_tb;

  // Parser states of the behavioral copy.
  typedef enum logic [2:0] {
    ST_IDLE, ST_SKIP, ST_MAGIC, ST_EXT_LEN, ST_EXT, ST_SIZE, ST_PAYLOAD
  } parse_state_e;

  // One carrier file. A negative cut sends every hidden bit. A negative
  // mid_at means no register write inside the file.
  typedef struct {
    bit                                     set_cfg;
    logic [lsb_steg_pkg::SkipW-1:0]         skip_cfg;
    logic [lsb_steg_pkg::MagicW-1:0]        magic_cfg;
    logic [lsb_steg_pkg::WordW-1:0]         ext_cfg;
    int                                     skip_len;
    logic [lsb_steg_pkg::MagicW-1:0]        magic;
    logic [lsb_steg_pkg::WordW-1:0]         ext;
    logic [lsb_steg_pkg::WordW-1:0]         size;
    logic [7:0]                             pbase;
    logic [7:0]                             pstep;
    int                                     cut;
    int                                     trail;
    int                                     mid_at;
    logic [lsb_steg_pkg::CfgIdxW-1:0]       mid_idx;
    logic [lsb_steg_pkg::CfgDataW-1:0]      mid_val;
    bit                                     typed;
    lsb_steg_pkg::kind_e                    tkind;
  } file_case_t;

  logic                                 clk_i = 1'b0;
  logic                                 rst_ni = 1'b0;
  logic                                 cfg_we_i = 1'b0;
  logic [lsb_steg_pkg::CfgIdxW-1:0]     cfg_idx_i = '0;
  logic [lsb_steg_pkg::CfgDataW-1:0]    cfg_wdata_i = '0;
  logic                                 s_axis_tvalid = 1'b0;
  logic                                 s_axis_tready;
  logic [7:0]                           s_axis_tdata = '0;   // [7:0] image_byte
  logic                                 s_axis_tuser = 1'b0; // [0] first_byte
  logic                                 m_axis_tvalid;
  logic                                 m_axis_tready = 1'b0;
  logic [7:0]                           m_axis_tdata;        // [7:0] payload_byte
  logic [1:0]                           m_axis_tuser;        // [1:0] kind
  logic                                 m_axis_tlast;

  // Behavioral copy of the registers and the parser state.
  lsb_steg_pkg::cfg_t                   regs;
  parse_state_e                         pst;
  logic [lsb_steg_pkg::SkipW-1:0]       skip_cnt;
  logic [lsb_steg_pkg::BitCntW-1:0]     nbits;
  logic [lsb_steg_pkg::WordW-1:0]       shreg;
  logic [lsb_steg_pkg::WordW-1:0]       bytes_left;

  lsb_steg_pkg::result_t                expected_q[$];
  int                                   mismatches = 0;
  int                                   items_sent = 0;
  int                                   send_idle_pct = 26;
  int                                   recv_idle_pct = 81;
  int                                   stall_request = 0;
  bit                                   typed_row = 1'b0;

  file_case_t                           dir_cases[13];

  always #1 clk_i = ~clk_i;

  lsb_stego_stream_extractor dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    // Keep the log short when the design is badly broken.
    if (mismatches < 40) begin
      $display("%0t mismatch: %s got %0h expected %0h", $realtime, what, got, want);
    end
    mismatches++;
  endtask

  function automatic void enter_state(input parse_state_e s);
    pst   = s;
    nbits = '0;
    shreg = '0;
  endfunction

  function automatic void reset_parser();
    regs       = '{header_skip: lsb_steg_pkg::HeaderSkipRst,
                   magic_word: lsb_steg_pkg::MagicWordRst,
                   extension_word: lsb_steg_pkg::ExtensionWordRst};
    skip_cnt   = '0;
    bytes_left = '0;
    enter_state(ST_IDLE);
  endfunction

  // Advances the parser copy by one image byte. Returns 1 when the byte
  // completes a result word, which is then handed back in res.
  function automatic bit extract_step(input logic [7:0] img, input logic sof,
                                      output lsb_steg_pkg::result_t res);
    logic [lsb_steg_pkg::BitCntW-1:0] need;
    res = '{kind: lsb_steg_pkg::KIND_PAYLOAD, payload_byte: 8'h00, last: 1'b0};
    if (sof) begin
      skip_cnt   = '0;
      bytes_left = '0;
      enter_state(regs.header_skip == '0 ? ST_MAGIC : ST_SKIP);
    end
    if (pst == ST_SKIP) begin
      // A lowered skip length ends the skip as soon as the count reaches it;
      // the count wrapping to zero also ends it.
      skip_cnt = skip_cnt + lsb_steg_pkg::SkipW'(1);
      if (skip_cnt >= regs.header_skip || skip_cnt == '0) enter_state(ST_MAGIC);
      return 1'b0;
    end
    if (pst == ST_IDLE) return 1'b0;

    shreg = {shreg[lsb_steg_pkg::WordW-2:0], img[0]};
    nbits = nbits + lsb_steg_pkg::BitCntW'(1);
    need  = (pst == ST_MAGIC) ? lsb_steg_pkg::MagicBits :
            (pst == ST_PAYLOAD) ? lsb_steg_pkg::ByteBits : lsb_steg_pkg::WordBits;
    if (nbits < need) return 1'b0;

    case (pst)
      ST_MAGIC: begin
        if (shreg[lsb_steg_pkg::MagicW-1:0] != regs.magic_word) begin
          enter_state(ST_IDLE);
          res.kind = lsb_steg_pkg::KIND_MAGIC_ERR;
          res.last = 1'b1;
          return 1'b1;
        end
        enter_state(ST_EXT_LEN);
      end
      ST_EXT_LEN: enter_state(ST_EXT);
      ST_EXT: begin
        if (shreg != regs.extension_word) begin
          enter_state(ST_IDLE);
          res.kind = lsb_steg_pkg::KIND_EXT_ERR;
          res.last = 1'b1;
          return 1'b1;
        end
        enter_state(ST_SIZE);
      end
      ST_SIZE: begin
        bytes_left = shreg;
        if (bytes_left == '0) begin
          enter_state(ST_IDLE);
          res.kind = lsb_steg_pkg::KIND_DONE;
          res.last = 1'b1;
          return 1'b1;
        end
        enter_state(ST_PAYLOAD);
      end
      default: begin
        res.payload_byte = shreg[7:0];
        bytes_left       = bytes_left - lsb_steg_pkg::WordW'(1);
        res.last         = (bytes_left == '0);
        enter_state(bytes_left == '0 ? ST_IDLE : ST_PAYLOAD);
        return 1'b1;
      end
    endcase
    return 1'b0;
  endfunction

  // Offers one image byte after a random gap and waits until it is taken.
  task automatic send_byte(input logic [7:0] img, input logic sof);
    lsb_steg_pkg::result_t r;
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= img;
    s_axis_tuser  <= sof;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
    // Idling pattern: light sender and busy receiver, then swapped, then none.
    if (items_sent == 1200) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (items_sent == 600) begin
      send_idle_pct = 81;
      recv_idle_pct = 26;
    end
    if (extract_step(img, sof, r)) begin
      if (!typed_row) expected_q.push_back(r);
    end
  endtask

  // Stops the input and waits until every predicted word has come out and
  // the result path has gone quiet.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [lsb_steg_pkg::CfgIdxW-1:0] idx,
                           input logic [lsb_steg_pkg::CfgDataW-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      lsb_steg_pkg::RegHeaderSkip:    regs.header_skip    = val[lsb_steg_pkg::SkipW-1:0];
      lsb_steg_pkg::RegMagicWord:     regs.magic_word     = val[lsb_steg_pkg::MagicW-1:0];
      lsb_steg_pkg::RegExtensionWord: regs.extension_word = val;
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Builds the carrier bytes of one file and sends them. Hidden bits ride in
  // bit 0 of each byte after the header; the upper bits are random.
  task automatic send_file(input file_case_t fc);
    logic [7:0]  carrier[$];
    bit          hidden[$];
    logic [31:0] extlen;
    logic [7:0]  pb;
    int          i;
    int          p;
    extlen = $urandom;
    for (i = 0; i < fc.skip_len; i++) carrier.push_back(8'($urandom));
    for (i = lsb_steg_pkg::MagicW - 1; i >= 0; i--) hidden.push_back(fc.magic[i]);
    for (i = lsb_steg_pkg::WordW - 1; i >= 0; i--) hidden.push_back(extlen[i]);
    for (i = lsb_steg_pkg::WordW - 1; i >= 0; i--) hidden.push_back(fc.ext[i]);
    for (i = lsb_steg_pkg::WordW - 1; i >= 0; i--) hidden.push_back(fc.size[i]);
    for (p = 0; p < int'(fc.size); p++) begin
      pb = fc.pbase + 8'(p) * fc.pstep;
      for (i = 7; i >= 0; i--) hidden.push_back(pb[i]);
    end
    if (fc.cut >= 0) begin
      while (hidden.size() > fc.cut) void'(hidden.pop_back());
    end
    foreach (hidden[h]) carrier.push_back({7'($urandom), hidden[h]});
    // Trailing bytes follow the hidden bits and, after a whole file, must give nothing.
    for (i = 0; i < fc.trail; i++) carrier.push_back(8'($urandom));

    for (i = 0; i < carrier.size(); i++) begin
      if (i == fc.mid_at) begin
        settle();
        write_reg(fc.mid_idx, fc.mid_val);
      end
      send_byte(carrier[i], i == 0);
    end
  endtask

  // Result side: checks every accepted word and drives tready with random
  // stalls, or with one long hold-off when the stimulus asks for it.
  initial begin : result_sink
    lsb_steg_pkg::result_t want;
    int                    hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        if (expected_q.size() == 0) begin
          report_mismatch("result word with nothing expected, kind",
                          32'(m_axis_tuser), '0);
        end else begin
          want = expected_q.pop_front();
          if (lsb_steg_pkg::kind_e'(m_axis_tuser) != want.kind)
            report_mismatch("kind", 32'(m_axis_tuser), 32'(want.kind));
          if (m_axis_tdata != want.payload_byte)
            report_mismatch("payload byte", 32'(m_axis_tdata), 32'(want.payload_byte));
          if (m_axis_tlast != want.last)
            report_mismatch("last flag", 32'(m_axis_tlast), 32'(want.last));
        end
      end
      if (stall_request > 0) begin
        hold_left     = stall_request;
        stall_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  initial begin : watchdog
    #2_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stimulus
    file_case_t            fc;
    lsb_steg_pkg::result_t typed_res;
    int                    i;
    int                    pick;
    int                    files;
    int                    len;
    int                    guard;
    bit                    pressed;
    bit                    noise_sof;

    // Directed files. Rows whose outcome is plain (the default settings, the
    // error codes, an empty payload) carry the expected word; the rest go
    // through the predictor. A row that leaves set_cfg clear keeps the
    // registers as they stand.
    dir_cases = '{
      // Default registers, empty payload, trailing bytes ignored.
      '{0, 0, 0, 0, 54, lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst,
        0, 8'h00, 8'h00, -1, 3, -1, lsb_steg_pkg::RegHeaderSkip, 0, 1,
        lsb_steg_pkg::KIND_DONE},
      // Magic off by one bit.
      '{0, 0, 0, 0, 54, 16'h2327, lsb_steg_pkg::ExtensionWordRst,
        0, 8'h00, 8'h00, -1, 0, -1, lsb_steg_pkg::RegHeaderSkip, 0, 1,
        lsb_steg_pkg::KIND_MAGIC_ERR},
      // Extension off by one bit; the rest of the file is ignored.
      '{0, 0, 0, 0, 54, lsb_steg_pkg::MagicWordRst, 32'h2E74_7875,
        0, 8'h00, 8'h00, -1, 0, -1, lsb_steg_pkg::RegHeaderSkip, 0, 1,
        lsb_steg_pkg::KIND_EXT_ERR},
      // No header: the first byte already carries a hidden bit.
      '{1, 0, lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst, 0,
        lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst, 3,
        8'h41, 8'h01, -1, 2, -1, lsb_steg_pkg::RegHeaderSkip, 0, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      // All-zero magic and extension.
      '{1, 0, 16'h0000, 32'h0000_0000, 0, 16'h0000, 32'h0000_0000, 2,
        8'h00, 8'hFF, -1, 0, -1, lsb_steg_pkg::RegHeaderSkip, 0, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      // All-ones magic and extension, one-byte header.
      '{1, 1, 16'hFFFF, 32'hFFFF_FFFF, 1, 16'hFFFF, 32'hFFFF_FFFF, 2,
        8'hFF, 8'h81, -1, 0, -1, lsb_steg_pkg::RegHeaderSkip, 0, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      // Largest header, lowered to 3 after five bytes: the sixth ends the skip.
      '{1, 16'hFFFF, lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst, 6,
        lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst, 1,
        8'hA5, 8'h00, -1, 0, 5, lsb_steg_pkg::RegHeaderSkip, 3, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      // File cut off inside the extension.
      '{1, 2, lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst, 2,
        lsb_steg_pkg::MagicWordRst, lsb_steg_pkg::ExtensionWordRst, 4,
        8'h10, 8'h10, 70, 0, -1, lsb_steg_pkg::RegHeaderSkip, 0, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      // A new file starts mid-file; the extension is changed during the magic.
      '{0, 0, 0, 0, 2, lsb_steg_pkg::MagicWordRst, 32'h2E6D_6431, 3, 8'h7E, 8'h11,
        -1, 0, 3, lsb_steg_pkg::RegExtensionWord, 32'h2E6D_6431, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      // Magic changed right as the hidden bits begin.
      '{0, 0, 0, 0, 2, 16'h4D5A, 32'h2E6D_6431, 1, 8'hC3, 8'h00,
        -1, 0, 2, lsb_steg_pkg::RegMagicWord, 16'h4D5A, 0,
        lsb_steg_pkg::KIND_PAYLOAD},
      '{1, 3, 16'hFFFF, lsb_steg_pkg::ExtensionWordRst, 3, 16'hFFFE,
        lsb_steg_pkg::ExtensionWordRst, 1, 8'h00, 8'h00, -1, 0, -1,
        lsb_steg_pkg::RegHeaderSkip, 0, 1, lsb_steg_pkg::KIND_MAGIC_ERR},
      '{1, 0, lsb_steg_pkg::MagicWordRst, 32'hFFFF_FFFF, 0, lsb_steg_pkg::MagicWordRst,
        32'h7FFF_FFFF, 1, 8'h00, 8'h00, -1, 0, -1, lsb_steg_pkg::RegHeaderSkip, 0, 1,
        lsb_steg_pkg::KIND_EXT_ERR},
      // Back to the defaults.
      '{1, lsb_steg_pkg::HeaderSkipRst, lsb_steg_pkg::MagicWordRst,
        lsb_steg_pkg::ExtensionWordRst, 54, lsb_steg_pkg::MagicWordRst,
        lsb_steg_pkg::ExtensionWordRst, 2, 8'h5A, 8'h33, -1, 0, -1,
        lsb_steg_pkg::RegHeaderSkip, 0, 0, lsb_steg_pkg::KIND_PAYLOAD}
    };

    reset_parser();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_cases[r]) begin
      settle();
      if (dir_cases[r].set_cfg) begin
        write_reg(lsb_steg_pkg::RegHeaderSkip,
                  lsb_steg_pkg::CfgDataW'(dir_cases[r].skip_cfg));
        write_reg(lsb_steg_pkg::RegMagicWord,
                  lsb_steg_pkg::CfgDataW'(dir_cases[r].magic_cfg));
        write_reg(lsb_steg_pkg::RegExtensionWord, dir_cases[r].ext_cfg);
      end
      if (dir_cases[r].typed) begin
        typed_res = '{kind: dir_cases[r].tkind, payload_byte: 8'h00, last: 1'b1};
        expected_q.push_back(typed_res);
      end
      typed_row = dir_cases[r].typed;
      send_file(dir_cases[r]);
      typed_row = 1'b0;
    end

    // Random files: mostly well-formed with random content, some with a bad
    // marker, cut short, padded at the end, or plain noise.
    files   = 0;
    pressed = 1'b0;
    while (items_sent < 1900 || !pressed) begin
      if (files % 3 == 0) begin
        settle();
        write_reg(lsb_steg_pkg::RegHeaderSkip,
                  ($urandom_range(9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 6));
        write_reg(lsb_steg_pkg::RegMagicWord, $urandom_range(16'hFFFF));
        write_reg(lsb_steg_pkg::RegExtensionWord, $urandom);
      end

      pick = $urandom_range(99);
      if (pick < 5) begin
        len       = $urandom_range(1, 20);
        noise_sof = 1'($urandom_range(1));
        for (i = 0; i < len; i++) send_byte(8'($urandom), noise_sof && i == 0);
      end else begin
        fc          = dir_cases[0];
        fc.typed    = 1'b0;
        fc.skip_len = int'(regs.header_skip);
        fc.magic    = ($urandom_range(99) < 88) ? regs.magic_word
                                                : 16'($urandom_range(16'hFFFF));
        fc.ext      = ($urandom_range(99) < 88) ? regs.extension_word : $urandom;
        pick        = $urandom_range(99);
        fc.size     = (pick < 10) ? 0 : (pick < 90) ? $urandom_range(1, 10)
                                                    : $urandom_range(11, 40);
        fc.pbase    = 8'($urandom);
        fc.pstep    = 8'($urandom) | 8'h01;
        fc.cut      = ($urandom_range(9) == 0) ? $urandom_range(0, 111 + 8 * fc.size) : -1;
        fc.trail    = ($urandom_range(4) == 0) ? $urandom_range(1, 6) : 0;
        fc.mid_at   = -1;
        // Once, with no idling, the result side holds off for a long stretch
        // during a payload so that the block backs up onto its input.
        if (!pressed && items_sent >= 1200) begin
          pressed       = 1'b1;
          fc.magic      = regs.magic_word;
          fc.ext        = regs.extension_word;
          fc.size       = 12;
          fc.cut        = -1;
          stall_request = 400;
        end
        send_file(fc);
      end
      files++;
    end

    s_axis_tvalid <= 1'b0;
    for (guard = 0; expected_q.size() != 0 && guard < 20000; guard++) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (expected_q.size() != 0)
      report_mismatch("words never delivered", '0, 32'(expected_q.size()));
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/lsb_steg_pkg.sv
hw/rtl/lsb_steg_cfg_regs.sv
hw/rtl/lsb_steg_parser.sv
hw/rtl/lsb_steg_out_buf.sv
hw/rtl/lsb_stego_stream_extractor.sv
verif/lsb_stego_stream_extractor_tb.sv
